// ----- hw/rtl/qslerp_pkg.sv -----
// Types, constants and angle table shared by the quaternion slerp pipeline.
package qslerp_pkg;

   localparam int CORDIC_STAGES = 16;
   localparam int TABLE_LEN = 24;
   localparam int CV_STAGES = (CORDIC_STAGES < TABLE_LEN) ? CORDIC_STAGES : TABLE_LEN;
   localparam int SQ_STEPS = 29;   // root bits of a 57-bit radicand
   localparam int DIV_STEPS = 29;  // quotient bits of a weight

   localparam logic [34:0] ONE28 = 35'd268435456;
   localparam logic signed [16:0] Q14_ONE = 17'sd16384;
   localparam logic signed [20:0] ANG_PI = 21'sd205887;
   localparam logic signed [20:0] ANG_HALF_PI = 21'sd102944;
   localparam logic signed [20:0] ANG_2PI = 21'sd411774;
   localparam logic signed [31:0] CORDIC_KINV = 32'sd163008219;

   // round(atan(2^-i) * 2^16)
   localparam logic signed [19:0] ATAN_TAB [TABLE_LEN] = '{
      20'sd51472, 20'sd30386, 20'sd16055, 20'sd8150, 20'sd4091, 20'sd2047,
      20'sd1024, 20'sd512, 20'sd256, 20'sd128, 20'sd64, 20'sd32,
      20'sd16, 20'sd8, 20'sd4, 20'sd2, 20'sd1, 20'sd0,
      20'sd0, 20'sd0, 20'sd0, 20'sd0, 20'sd0, 20'sd0
   };

   typedef struct packed {
      logic signed [15:0] p_x;
      logic signed [15:0] p_y;
      logic signed [15:0] p_z;
      logic signed [15:0] p_w;
      logic signed [15:0] q_x;
      logic signed [15:0] q_y;
      logic signed [15:0] q_z;
      logic signed [15:0] q_w;
      logic [14:0]        blend;
   } req_type;

   typedef struct packed {
      logic signed [15:0] r_x;
      logic signed [15:0] r_y;
      logic signed [15:0] r_z;
      logic signed [15:0] r_w;
      logic               q_flipped;
      logic               opposite_path;
   } rsp_type;

   typedef struct packed {
      logic [3:0][15:0] p;
      logic [3:0][16:0] q;
      logic [14:0]      blend;
      logic             flip;
      logic             lin;
   } side_type;

   typedef struct packed {
      side_type    sd;
      logic [27:0] ctr;
      logic [57:0] rem;
      logic [57:0] res;
   } sq_type;

   typedef struct packed {
      side_type           sd;
      logic [28:0]        s;
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic signed [19:0] z;
   } cv_type;

   typedef struct packed {
      side_type    sd;
      logic [28:0] s;
      logic [17:0] w;
   } an_type;

   typedef struct packed {
      side_type           sd;
      logic [28:0]        s;
      logic signed [35:0] pa;
      logic signed [35:0] pb;
   } ml_type;

   typedef struct packed {
      side_type           sd;
      logic [28:0]        s;
      logic signed [20:0] aa;
      logic signed [20:0] ab;
   } rn_type;

   typedef struct packed {
      logic               neg;
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic signed [19:0] z;
   } lane_type;

   typedef struct packed {
      side_type           sd;
      logic [28:0]        s;
      lane_type [1:0]     ln;
   } cr_type;

   typedef struct packed {
      logic        sgn;
      logic [43:0] rem;
      logic [28:0] quo;
   } dl_type;

   typedef struct packed {
      side_type     sd;
      logic [28:0]  s;
      dl_type [1:0] ln;
   } dv_type;

   typedef struct packed {
      side_type           sd;
      logic signed [29:0] wp;
      logic signed [29:0] wq;
   } wt_type;

   typedef struct packed {
      logic             flip;
      logic [3:0][46:0] pw;
      logic [3:0][46:0] qw;
   } mp_type;

   typedef struct packed {
      logic             flip;
      logic [3:0][47:0] sum;
   } sm_type;

endpackage

// ----- hw/rtl/quaternion_slerp_core.sv -----
// Quaternion slerp core: fully pipelined, one beat in per cycle, no stall.
// The pipeline depth is set by the 29-step root, two CORDIC chains and the 29-step
// divider. Throughput: one beat per cycle; busy is never raised.
// Reset (synchronous) clears all valid bits and near_limit; data registers are not reset.
module quaternion_slerp_core (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  qslerp_pkg::req_type req_data,
   input  logic                csr_wr_en,
   input  logic [7:0]          csr_wr_data,
   output logic                rsp_valid,
   output qslerp_pkg::rsp_type rsp_data
);

   localparam int CVN = qslerp_pkg::CV_STAGES;
   localparam int SQN = qslerp_pkg::SQ_STEPS;
   localparam int DVN = qslerp_pkg::DIV_STEPS;

   // ---------------------------------------------------------------- step functions
   function automatic qslerp_pkg::sq_type sq_step(input qslerp_pkg::sq_type a, input int j);
      logic [57:0] bitv;
      logic [57:0] trial;
      qslerp_pkg::sq_type r;
      r = a;
      bitv = 58'd1 << (2 * (SQN - 1 - j));
      trial = a.res + bitv;
      if (a.rem >= trial) begin
         r.rem = a.rem - trial;
         r.res = (a.res >> 1) + bitv;
      end else begin
         r.res = a.res >> 1;
      end
      return r;
   endfunction

   // vectoring: drive y to zero, accumulate angle
   function automatic qslerp_pkg::cv_type cv_step(input qslerp_pkg::cv_type a, input int i);
      qslerp_pkg::cv_type r;
      r = a;
      if (a.y > 0) begin
         r.x = a.x + (a.y >>> i);
         r.y = a.y - (a.x >>> i);
         r.z = a.z + qslerp_pkg::ATAN_TAB[i];
      end else begin
         r.x = a.x - (a.y >>> i);
         r.y = a.y + (a.x >>> i);
         r.z = a.z - qslerp_pkg::ATAN_TAB[i];
      end
      return r;
   endfunction

   // rotation: drive z to zero, y ends as the sine
   function automatic qslerp_pkg::cr_type cr_step(input qslerp_pkg::cr_type a, input int i);
      qslerp_pkg::cr_type r;
      r = a;
      for (int l = 0; l < 2; l++) begin
         if (!a.ln[l].z[19]) begin
            r.ln[l].x = a.ln[l].x - (a.ln[l].y >>> i);
            r.ln[l].y = a.ln[l].y + (a.ln[l].x >>> i);
            r.ln[l].z = a.ln[l].z - qslerp_pkg::ATAN_TAB[i];
         end else begin
            r.ln[l].x = a.ln[l].x + (a.ln[l].y >>> i);
            r.ln[l].y = a.ln[l].y - (a.ln[l].x >>> i);
            r.ln[l].z = a.ln[l].z + qslerp_pkg::ATAN_TAB[i];
         end
      end
      return r;
   endfunction

   // restoring divide, one quotient bit per stage
   function automatic qslerp_pkg::dv_type dv_step(input qslerp_pkg::dv_type a, input int j);
      logic [57:0] dsh;
      logic [57:0] num;
      qslerp_pkg::dv_type r;
      r = a;
      dsh = 58'(a.s) << (DVN - 1 - j);
      for (int l = 0; l < 2; l++) begin
         num = {14'b0, a.ln[l].rem};
         if (num >= dsh) begin
            r.ln[l].rem = 44'(num - dsh);
            r.ln[l].quo = a.ln[l].quo | (29'd1 << (DVN - 1 - j));
         end
      end
      return r;
   endfunction

   // fold an angle of any sign into [0, pi/2] plus a sign, seed the rotation
   function automatic qslerp_pkg::lane_type reduce_lane(input logic signed [20:0] ang);
      logic signed [20:0] mag;
      qslerp_pkg::lane_type r;
      r.neg = ang[20];
      mag = ang[20] ? -ang : ang;
      if (mag >= qslerp_pkg::ANG_2PI) mag = mag - qslerp_pkg::ANG_2PI;
      if (mag > qslerp_pkg::ANG_PI) begin
         mag = mag - qslerp_pkg::ANG_PI;
         r.neg = ~r.neg;
      end
      if (mag > qslerp_pkg::ANG_HALF_PI) begin
         r.x = '0;
         r.y = qslerp_pkg::CORDIC_KINV;
         r.z = 20'(mag - qslerp_pkg::ANG_HALF_PI);
      end else begin
         r.x = qslerp_pkg::CORDIC_KINV;
         r.y = '0;
         r.z = mag[19:0];
      end
      return r;
   endfunction

   // ---------------------------------------------------------------- registers
   logic [7:0]               near_limit_ff, near_limit_in;

   logic                     v1_ff, v2_ff, v3_ff, v4_ff;
   qslerp_pkg::req_type      req1_ff, req2_ff;
   logic signed [31:0]       pp1_ff [4];
   logic signed [31:0]       pp1_in [4];
   logic signed [33:0]       c2_ff, c2_in;
   qslerp_pkg::side_type     sd3_ff, sd3_in, sd4_ff;
   logic [27:0]              ctr3_ff, ctr3_in, ctr4_ff;
   logic [55:0]              csq4_ff, csq4_in;

   logic [SQN:0]             sq_v_ff;
   qslerp_pkg::sq_type       sq_ff [SQN+1];
   qslerp_pkg::sq_type       sq_in [SQN+1];
   logic [CVN:0]             cv_v_ff;
   qslerp_pkg::cv_type       cv_ff [CVN+1];
   qslerp_pkg::cv_type       cv_in [CVN+1];
   logic                     an_v_ff, ml_v_ff, rn_v_ff;
   qslerp_pkg::an_type       an_ff, an_in;
   qslerp_pkg::ml_type       ml_ff, ml_in;
   qslerp_pkg::rn_type       rn_ff, rn_in;
   logic [CVN:0]             cr_v_ff;
   qslerp_pkg::cr_type       cr_ff [CVN+1];
   qslerp_pkg::cr_type       cr_in [CVN+1];
   logic [DVN:0]             dv_v_ff;
   qslerp_pkg::dv_type       dv_ff [DVN+1];
   qslerp_pkg::dv_type       dv_in [DVN+1];
   logic                     wt_v_ff, mp_v_ff, sm_v_ff, rsp_valid_ff;
   qslerp_pkg::wt_type       wt_ff, wt_in;
   qslerp_pkg::mp_type       mp_ff, mp_in;
   qslerp_pkg::sm_type       sm_ff, sm_in;
   qslerp_pkg::rsp_type      rsp_ff, rsp_in;

   assign busy = 1'b0;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;
   assign near_limit_in = csr_wr_en ? csr_wr_data : near_limit_ff;

   // ---------------------------------------------------------------- dot product
   logic signed [15:0] pin [4];
   logic signed [15:0] qin [4];

   always_comb begin
      pin = '{req_data.p_x, req_data.p_y, req_data.p_z, req_data.p_w};
      qin = '{req_data.q_x, req_data.q_y, req_data.q_z, req_data.q_w};
      for (int i = 0; i < 4; i++) begin
         pp1_in[i] = pin[i] * qin[i];
      end
   end

   assign c2_in = 34'(pp1_ff[0]) + 34'(pp1_ff[1]) + 34'(pp1_ff[2]) + 34'(pp1_ff[3]);

   // flip to the short arc; since c >= 0 afterwards, the nearly-opposite test
   // (one + c <= margin) can never pass, so only linear and trig paths remain
   logic               flip3;
   logic [33:0]        cabs3;
   logic [34:0]        lim3;
   logic signed [15:0] qraw3 [4];
   logic signed [16:0] qext3;

   always_comb begin
      flip3 = c2_ff[33];
      cabs3 = flip3 ? -c2_ff : c2_ff;
      lim3 = {13'b0, near_limit_ff, 14'b0};
      qraw3 = '{req2_ff.q_x, req2_ff.q_y, req2_ff.q_z, req2_ff.q_w};
      sd3_in.p[0] = req2_ff.p_x;
      sd3_in.p[1] = req2_ff.p_y;
      sd3_in.p[2] = req2_ff.p_z;
      sd3_in.p[3] = req2_ff.p_w;
      for (int i = 0; i < 4; i++) begin
         qext3 = 17'(qraw3[i]);
         sd3_in.q[i] = flip3 ? -qext3 : qext3;
      end
      sd3_in.blend = req2_ff.blend;
      sd3_in.flip = flip3;
      sd3_in.lin = ({1'b0, cabs3} + lim3) >= qslerp_pkg::ONE28;
      ctr3_in = cabs3[27:0];
   end

   assign csq4_in = ctr3_ff * ctr3_ff;

   // ---------------------------------------------------------------- square root
   always_comb begin
      sq_in[0].sd = sd4_ff;
      sq_in[0].ctr = ctr4_ff;
      sq_in[0].rem = (58'd1 << 56) - {2'b0, csq4_ff};
      sq_in[0].res = '0;
      for (int j = 0; j < SQN; j++) begin
         sq_in[j+1] = sq_step(sq_ff[j], j);
      end
   end

   // ---------------------------------------------------------------- acos by vectoring
   always_comb begin
      cv_in[0].sd = sq_ff[SQN].sd;
      cv_in[0].s = sq_ff[SQN].res[28:0];
      cv_in[0].x = {4'b0, sq_ff[SQN].ctr};
      cv_in[0].y = {3'b0, sq_ff[SQN].res[28:0]};
      cv_in[0].z = '0;
      for (int i = 0; i < CVN; i++) begin
         cv_in[i+1] = cv_step(cv_ff[i], i);
      end
   end

   always_comb begin
      an_in.sd = cv_ff[CVN].sd;
      an_in.s = cv_ff[CVN].s;
      if (cv_ff[CVN].z[19]) begin
         an_in.w = '0;
      end else if (21'(cv_ff[CVN].z) > qslerp_pkg::ANG_PI) begin
         an_in.w = qslerp_pkg::ANG_PI[17:0];
      end else begin
         an_in.w = cv_ff[CVN].z[17:0];
      end
   end

   // ---------------------------------------------------------------- blend angles
   logic signed [16:0] u_ml;
   logic signed [16:0] t_ml;
   logic signed [18:0] w_ml;

   always_comb begin
      t_ml = $signed({2'b0, an_ff.sd.blend});
      u_ml = qslerp_pkg::Q14_ONE - t_ml;
      w_ml = $signed({1'b0, an_ff.w});
      ml_in.sd = an_ff.sd;
      ml_in.s = an_ff.s;
      ml_in.pa = u_ml * w_ml;
      ml_in.pb = t_ml * w_ml;
   end

   logic signed [35:0] ra_rn, rb_rn;

   always_comb begin
      ra_rn = ml_ff.pa + 36'sd8192;
      rb_rn = ml_ff.pb + 36'sd8192;
      rn_in.sd = ml_ff.sd;
      rn_in.s = ml_ff.s;
      rn_in.aa = ra_rn[34:14];
      rn_in.ab = rb_rn[34:14];
   end

   // ---------------------------------------------------------------- sines
   always_comb begin
      cr_in[0].sd = rn_ff.sd;
      cr_in[0].s = rn_ff.s;
      cr_in[0].ln[0] = reduce_lane(rn_ff.aa);
      cr_in[0].ln[1] = reduce_lane(rn_ff.ab);
      for (int i = 0; i < CVN; i++) begin
         cr_in[i+1] = cr_step(cr_ff[i], i);
      end
   end

   // ---------------------------------------------------------------- divide by s
   logic [31:0] mag_dv;

   always_comb begin
      dv_in[0].sd = cr_ff[CVN].sd;
      dv_in[0].s = cr_ff[CVN].s;
      for (int l = 0; l < 2; l++) begin
         mag_dv = cr_ff[CVN].ln[l].y[31] ? -cr_ff[CVN].ln[l].y : cr_ff[CVN].ln[l].y;
         dv_in[0].ln[l].sgn = cr_ff[CVN].ln[l].neg ^ cr_ff[CVN].ln[l].y[31];
         dv_in[0].ln[l].rem = {mag_dv[29:0], 14'b0};
         dv_in[0].ln[l].quo = '0;
      end
      for (int j = 0; j < DVN; j++) begin
         dv_in[j+1] = dv_step(dv_ff[j], j);
      end
   end

   // ---------------------------------------------------------------- weights and output
   logic signed [16:0] lin_wp;
   logic signed [29:0] qa_wt, qb_wt;

   always_comb begin
      lin_wp = qslerp_pkg::Q14_ONE - $signed({2'b0, dv_ff[DVN].sd.blend});
      qa_wt = {1'b0, dv_ff[DVN].ln[0].quo};
      qb_wt = {1'b0, dv_ff[DVN].ln[1].quo};
      wt_in.sd = dv_ff[DVN].sd;
      if (dv_ff[DVN].sd.lin) begin
         wt_in.wp = 30'(lin_wp);
         wt_in.wq = {15'b0, dv_ff[DVN].sd.blend};
      end else begin
         wt_in.wp = dv_ff[DVN].ln[0].sgn ? -qa_wt : qa_wt;
         wt_in.wq = dv_ff[DVN].ln[1].sgn ? -qb_wt : qb_wt;
      end
   end

   logic signed [46:0] pw_mp, qw_mp;

   always_comb begin
      mp_in.flip = wt_ff.sd.flip;
      for (int i = 0; i < 4; i++) begin
         pw_mp = wt_ff.wp * $signed(wt_ff.sd.p[i]);
         qw_mp = wt_ff.wq * $signed(wt_ff.sd.q[i]);
         mp_in.pw[i] = pw_mp;
         mp_in.qw[i] = qw_mp;
      end
   end

   logic signed [47:0] sv_sm;

   always_comb begin
      sm_in.flip = mp_ff.flip;
      for (int i = 0; i < 4; i++) begin
         sv_sm = $signed(mp_ff.pw[i]) + $signed(mp_ff.qw[i]);
         sm_in.sum[i] = sv_sm;
      end
   end

   logic signed [48:0] rt_out;
   logic signed [34:0] val_out;
   logic signed [15:0] rv_out [4];

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         rt_out = $signed(sm_ff.sum[i]) + 49'sd8192;
         val_out = rt_out[48:14];
         if (val_out > 35'sd32767) begin
            rv_out[i] = 16'sh7fff;
         end else if (val_out < -35'sd32768) begin
            rv_out[i] = -16'sh8000;
         end else begin
            rv_out[i] = val_out[15:0];
         end
      end
      rsp_in.r_x = rv_out[0];
      rsp_in.r_y = rv_out[1];
      rsp_in.r_z = rv_out[2];
      rsp_in.r_w = rv_out[3];
      rsp_in.q_flipped = sm_ff.flip;
      rsp_in.opposite_path = 1'b0;
   end

   // ---------------------------------------------------------------- control state
   always_ff @(posedge clock) begin
      if (reset) begin
         near_limit_ff <= '0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         sq_v_ff <= '0;
         cv_v_ff <= '0;
         an_v_ff <= 1'b0;
         ml_v_ff <= 1'b0;
         rn_v_ff <= 1'b0;
         cr_v_ff <= '0;
         dv_v_ff <= '0;
         wt_v_ff <= 1'b0;
         mp_v_ff <= 1'b0;
         sm_v_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         near_limit_ff <= near_limit_in;
         v1_ff <= start;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         sq_v_ff <= {sq_v_ff[SQN-1:0], v4_ff};
         cv_v_ff <= {cv_v_ff[CVN-1:0], sq_v_ff[SQN]};
         an_v_ff <= cv_v_ff[CVN];
         ml_v_ff <= an_v_ff;
         rn_v_ff <= ml_v_ff;
         cr_v_ff <= {cr_v_ff[CVN-1:0], rn_v_ff};
         dv_v_ff <= {dv_v_ff[DVN-1:0], cr_v_ff[CVN]};
         wt_v_ff <= dv_v_ff[DVN];
         mp_v_ff <= wt_v_ff;
         sm_v_ff <= mp_v_ff;
         rsp_valid_ff <= sm_v_ff;
      end
   end

   // ---------------------------------------------------------------- data path
   always_ff @(posedge clock) begin
      req1_ff <= req_data;
      pp1_ff <= pp1_in;
      req2_ff <= req1_ff;
      c2_ff <= c2_in;
      sd3_ff <= sd3_in;
      ctr3_ff <= ctr3_in;
      sd4_ff <= sd3_ff;
      ctr4_ff <= ctr3_ff;
      csq4_ff <= csq4_in;
      for (int j = 0; j <= SQN; j++) begin
         sq_ff[j] <= sq_in[j];
      end
      for (int i = 0; i <= CVN; i++) begin
         cv_ff[i] <= cv_in[i];
         cr_ff[i] <= cr_in[i];
      end
      an_ff <= an_in;
      ml_ff <= ml_in;
      rn_ff <= rn_in;
      for (int j = 0; j <= DVN; j++) begin
         dv_ff[j] <= dv_in[j];
      end
      wt_ff <= wt_in;
      mp_ff <= mp_in;
      sm_ff <= sm_in;
      rsp_ff <= rsp_in;
   end

endmodule
